// ===== src/cpr_pkg.sv =====
package cpr_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

    localparam logic [1:0] CMD_VICTIM = 2'd0;
    localparam logic [1:0] CMD_PIN    = 2'd1;
    localparam logic [1:0] CMD_UNPIN  = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] frame;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [5:0] victim_frame;
        logic [6:0] evictable_count;
    } resp_t;

    typedef struct packed {
        logic load;
        logic rotate;
        logic group;
        logic pick;
        logic apply;
    } ctrl_t;

    typedef struct packed {
        logic sweep;
    } stat_t;

endpackage

// ===== src/cpr_ctrl.sv =====
module cpr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    output logic            resp_valid,
    input  logic            resp_stall,
    input  cpr_pkg::stat_t  stat,
    output cpr_pkg::ctrl_t  ctrl
);
    import cpr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROTATE,
        S_GROUP,
        S_PICK,
        S_APPLY
    } state_t;

    state_t state_reg, state_next;
    logic   resp_valid_reg, resp_valid_next;

    assign req_stall  = (state_reg != S_IDLE);
    assign resp_valid = resp_valid_reg;

    always_comb
    begin
        ctrl.load   = (state_reg == S_IDLE) && req_valid;
        ctrl.rotate = (state_reg == S_ROTATE);
        ctrl.group  = (state_reg == S_GROUP);
        ctrl.pick   = (state_reg == S_PICK);
        // hold the result until the output register is free
        ctrl.apply  = (state_reg == S_APPLY) && (!resp_valid_reg || !resp_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_ROTATE;
            end
            S_ROTATE:
            begin
                state_next = stat.sweep ? S_GROUP : S_APPLY;
            end
            S_GROUP:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (ctrl.apply)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ctrl.apply)
            resp_valid_next = 1'b1;
        else if (!resp_stall)
            resp_valid_next = 1'b0;
        else
            resp_valid_next = resp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

endmodule

// ===== src/cpr_datapath.sv =====
module cpr_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  cpr_pkg::ctrl_t  ctrl,
    output cpr_pkg::stat_t  stat,
    input  cpr_pkg::req_t   req,
    output cpr_pkg::resp_t  resp
);
    import cpr_pkg::*;

    localparam int GROUPS = (NUM_FRAMES + 7) / 8;
    localparam int PAD_W  = GROUPS * 8;
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int WIDE_W = ((FRAME_W > 6) ? FRAME_W : 6) + 1;

    logic [NUM_FRAMES-1:0] evict_reg, evict_next;
    logic [NUM_FRAMES-1:0] ref_reg, ref_next;
    logic [FRAME_W-1:0]    hand_reg, hand_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    req_t                  req_reg;
    logic [PAD_W-1:0]      a_rot_reg, a_rot_next;
    logic [PAD_W-1:0]      b_rot_reg, b_rot_next;
    logic [GROUPS-1:0]     a_any_reg, a_any_next;
    logic [GROUPS-1:0]     b_any_reg, b_any_next;
    logic [2:0]            a_low_reg [GROUPS];
    logic [2:0]            a_low_next [GROUPS];
    logic [2:0]            b_low_reg [GROUPS];
    logic [2:0]            b_low_next [GROUPS];
    logic [FRAME_W-1:0]    off_reg, off_next;
    logic                  use_b_reg, use_b_next;
    resp_t                 resp_reg, resp_next;

    logic [WIDE_W-1:0]     frame_wide;
    logic                  frame_ok;
    logic [FRAME_W-1:0]    frame_idx;
    logic [FRAME_W-1:0]    victim_idx;

    function automatic logic [FRAME_W-1:0] wrap_add(input logic [FRAME_W-1:0] base,
                                                    input logic [FRAME_W-1:0] step);
        logic [FRAME_W:0] sum;
        sum = {1'b0, base} + {1'b0, step};
        if (sum >= (FRAME_W+1)'(NUM_FRAMES))
            sum = sum - (FRAME_W+1)'(NUM_FRAMES);
        return sum[FRAME_W-1:0];
    endfunction

    // distance from the hand to a position, walking forward around the ring
    function automatic logic [FRAME_W-1:0] ring_dist(input logic [FRAME_W-1:0] pos,
                                                     input logic [FRAME_W-1:0] from);
        logic [FRAME_W:0] diff;
        if (pos >= from)
            diff = {1'b0, pos} - {1'b0, from};
        else
            diff = {1'b0, pos} + (FRAME_W+1)'(NUM_FRAMES) - {1'b0, from};
        return diff[FRAME_W-1:0];
    endfunction

    assign stat.sweep = (req_reg.cmd == CMD_VICTIM) && (count_reg != '0);
    assign resp       = resp_reg;

    assign frame_wide = WIDE_W'(req_reg.frame);
    assign frame_ok   = frame_wide < WIDE_W'(NUM_FRAMES);
    assign frame_idx  = FRAME_W'(frame_wide);
    assign victim_idx = wrap_add(hand_reg, off_reg);

    // rotate the candidate masks so that the hand sits at bit zero
    always_comb
    begin : rotate_blk
        logic [FRAME_W-1:0] pos;
        a_rot_next = '0;
        b_rot_next = '0;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            pos           = wrap_add(hand_reg, FRAME_W'(i));
            a_rot_next[i] = evict_reg[pos] & ~ref_reg[pos];
            b_rot_next[i] = evict_reg[pos];
        end
    end

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            a_any_next[g] = |a_rot_reg[g*8 +: 8];
            b_any_next[g] = |b_rot_reg[g*8 +: 8];
            a_low_next[g] = 3'd0;
            b_low_next[g] = 3'd0;
            for (int k = 7; k >= 0; k--)
            begin
                if (a_rot_reg[g*8 + k])
                    a_low_next[g] = 3'(k);
                if (b_rot_reg[g*8 + k])
                    b_low_next[g] = 3'(k);
            end
        end
    end

    // first group wins; fall back to any evictable frame when all are referenced
    always_comb
    begin : pick_blk
        logic [GRP_W-1:0] a_sel;
        logic [GRP_W-1:0] b_sel;
        logic [GRP_W+2:0] off_wide;
        a_sel = '0;
        b_sel = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (a_any_reg[g])
                a_sel = GRP_W'(g);
            if (b_any_reg[g])
                b_sel = GRP_W'(g);
        end
        use_b_next = ~|a_any_reg;
        if (use_b_next)
            off_wide = {b_sel, b_low_reg[b_sel]};
        else
            off_wide = {a_sel, a_low_reg[a_sel]};
        off_next = FRAME_W'(off_wide);
    end

    always_comb
    begin
        evict_next = evict_reg;
        ref_next   = ref_reg;
        hand_next  = hand_reg;
        count_next = count_reg;
        resp_next.found        = 1'b0;
        resp_next.victim_frame = 6'd0;
        case (req_reg.cmd)
            CMD_VICTIM:
            begin
                if (count_reg != '0)
                begin
                    if (use_b_reg)
                        ref_next = ref_reg & ~evict_reg;
                    else
                    begin
                        for (int p = 0; p < NUM_FRAMES; p++)
                        begin
                            if (evict_reg[p] &&
                                ring_dist(FRAME_W'(p), hand_reg) < off_reg)
                                ref_next[p] = 1'b0;
                        end
                    end
                    evict_next[victim_idx] = 1'b0;
                    hand_next              = wrap_add(victim_idx, FRAME_W'(1));
                    count_next             = count_reg - CNT_W'(1);
                    resp_next.found        = 1'b1;
                    resp_next.victim_frame = 6'(victim_idx);
                end
            end
            CMD_PIN:
            begin
                if (frame_ok && evict_reg[frame_idx])
                begin
                    evict_next[frame_idx] = 1'b0;
                    count_next            = count_reg - CNT_W'(1);
                end
            end
            CMD_UNPIN:
            begin
                if (frame_ok && !evict_reg[frame_idx])
                begin
                    evict_next[frame_idx] = 1'b1;
                    ref_next[frame_idx]   = 1'b1;
                    count_next            = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
        resp_next.evictable_count = 7'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evict_reg <= '0;
            ref_reg   <= '0;
            hand_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctrl.apply)
        begin
            evict_reg <= evict_next;
            ref_reg   <= ref_next;
            hand_reg  <= hand_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            req_reg <= req;
        if (ctrl.rotate)
        begin
            a_rot_reg <= a_rot_next;
            b_rot_reg <= b_rot_next;
        end
        if (ctrl.group)
        begin
            a_any_reg <= a_any_next;
            b_any_reg <= b_any_next;
            a_low_reg <= a_low_next;
            b_low_reg <= b_low_next;
        end
        if (ctrl.pick)
        begin
            off_reg   <= off_next;
            use_b_reg <= use_b_next;
        end
        if (ctrl.apply)
            resp_reg <= resp_next;
    end

endmodule

// ===== src/clock_page_replacer.sv =====
// Steps: an accepted request passes the rotate and update steps; a victim request
// with a nonzero count also passes group search and pick (rotate, group search,
// pick, update). Intake: one request at a time; a new request is taken only after
// the last one is applied, and a stalled result holds the next request in its update
// step and stalls intake until the result is taken.
// Reset: asynchronous, active low; clears all marks, the hand, the count and result valid.
module clock_page_replacer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  cpr_pkg::req_t   req,
    output logic            resp_valid,
    input  logic            resp_stall,
    output cpr_pkg::resp_t  resp
);
    import cpr_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    cpr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .stat       (stat),
        .ctrl       (ctrl)
    );

    cpr_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .req   (req),
        .resp  (resp)
    );

endmodule
